FILE: sv/wavhdr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the WAV header chunk parser.
// No dependencies; imported by wav_header_chunk_parser.
package wavhdr_pkg;

  localparam int unsigned HEADER_LEN = 36;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_FORMAT   = 2'd0,
    KIND_PCM      = 2'd1,
    KIND_NO_DATA  = 2'd2,
    KIND_TRUNC    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [7:0]  sample_bits;
    logic [31:0] pcm_size;
    logic [7:0]  pcm_byte;
    logic        last;
  } result_t;

  function automatic logic [7:0] data_tag(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h64;
      2'd1:    ch = 8'h61;
      2'd2:    ch = 8'h74;
      default: ch = 8'h61;
    endcase
    return ch;
  endfunction

  function automatic result_t make_result(
    input kind_t       kind,
    input logic [7:0]  pcm,
    input logic        last,
    input logic [15:0] channels,
    input logic [31:0] rate,
    input logic [7:0]  bits,
    input logic [31:0] size
  );
    result_t r;
    logic    err;
    err           = (kind == KIND_NO_DATA);
    r.kind        = kind;
    r.channels    = err ? 16'd0 : channels;
    r.sample_rate = err ? 32'd0 : rate;
    r.sample_bits = err ? 8'd0 : bits;
    r.pcm_size    = err ? 32'd0 : size;
    r.pcm_byte    = pcm;
    r.last        = last;
    return r;
  endfunction

endpackage

FILE: sv/wav_header_chunk_parser.sv
`timescale 1ns / 1ps
// WAV header chunk parser: takes a WAV file one byte per word and emits a
// format word, the PCM bytes and error words. Depends on wavhdr_pkg.
//
// The input channel carries one file byte per word, with in_end_of_file set
// on the last byte of a file. The output channel carries result words: one
// format word when the data chunk header is complete, one word per PCM byte,
// and an error word when the file ends early or the data chunk is cut short.
// A byte is held in an input register, then parsed and written into a
// four-entry result queue when it has room; results leave from its head.
// One byte is taken per cycle while the queue has room for two results; a
// byte yields at most two results. When the receiver stalls, the queue fills
// and in_ready drops once three or more words are waiting. Reset clears the
// parser to the start of a file and empties the queue. After a byte with
// in_end_of_file set, the parser returns to the start of a file by itself.
module wav_header_chunk_parser
  import wavhdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_file_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_channels,
  output logic [31:0] out_sample_rate,
  output logic [7:0]  out_sample_bits,
  output logic [31:0] out_pcm_size,
  output logic [7:0]  out_pcm_byte,
  output logic        out_last
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_ID     = 3'd1,
    PH_SIZE   = 3'd2,
    PH_SKIP   = 3'd3,
    PH_DATA   = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  logic             stg_v_r;
  logic [7:0]       stg_byte_r;
  logic             stg_eof_r;

  phase_t           phase_r, phase_nxt;
  logic [5:0]       pos_r, pos_nxt;
  logic [31:0]      shift_r, shift_nxt;
  logic             is_data_r, is_data_nxt;
  logic [31:0]      remain_r, remain_nxt;
  logic [15:0]      chan_r, chan_nxt;
  logic [31:0]      rate_r, rate_nxt;
  logic [7:0]       bits_r, bits_nxt;
  logic [31:0]      size_r, size_nxt;

  result_t          fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr1;
  logic [CNT_W-1:0] cnt_r;

  logic             advance, pop;
  logic             push0, push1, closed;
  result_t          res0, res1, head;
  logic [5:0]       pos_inc;
  logic [31:0]      remain_dec;
  logic [31:0]      size_word;

  assign advance  = stg_v_r && (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_ready = !stg_v_r || advance;
  assign pop      = out_valid && out_ready;
  assign wr_ptr1  = wr_ptr_r + PTR_W'(1);

  assign pos_inc    = pos_r + 6'd1;
  assign remain_dec = remain_r - 32'd1;
  assign size_word  = {stg_byte_r, shift_r[31:8]};

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    shift_nxt   = shift_r;
    is_data_nxt = is_data_r;
    remain_nxt  = remain_r;
    chan_nxt    = chan_r;
    rate_nxt    = rate_r;
    bits_nxt    = bits_r;
    size_nxt    = size_r;
    push0       = 1'b0;
    push1       = 1'b0;
    closed      = 1'b0;
    res0        = make_result(KIND_NO_DATA, 8'd0, 1'b1, 16'd0, 32'd0, 8'd0, 32'd0);
    res1        = res0;

    unique case (phase_r)
      PH_HEADER: begin
        case (pos_r)
          6'd22:   chan_nxt[7:0]   = stg_byte_r;
          6'd23:   chan_nxt[15:8]  = stg_byte_r;
          6'd24:   rate_nxt[7:0]   = stg_byte_r;
          6'd25:   rate_nxt[15:8]  = stg_byte_r;
          6'd26:   rate_nxt[23:16] = stg_byte_r;
          6'd27:   rate_nxt[31:24] = stg_byte_r;
          6'd34:   bits_nxt        = stg_byte_r;
          default: ;
        endcase
        pos_nxt = pos_inc;
        if (pos_inc >= 6'(HEADER_LEN)) begin
          phase_nxt   = PH_ID;
          pos_nxt     = 6'd0;
          is_data_nxt = 1'b1;
        end
      end
      PH_ID: begin
        if (stg_byte_r != data_tag(pos_r[1:0])) begin
          is_data_nxt = 1'b0;
        end
        pos_nxt = pos_inc;
        if (pos_inc >= 6'd4) begin
          phase_nxt = PH_SIZE;
          pos_nxt   = 6'd0;
          shift_nxt = 32'd0;
        end
      end
      PH_SIZE: begin
        shift_nxt = size_word;
        pos_nxt   = pos_inc;
        if (pos_inc >= 6'd4) begin
          pos_nxt    = 6'd0;
          remain_nxt = size_word;
          if (is_data_r) begin
            size_nxt = size_word;
            push0    = 1'b1;
            if (size_word == 32'd0) begin
              res0      = make_result(KIND_FORMAT, 8'd0, 1'b1, chan_r, rate_r, bits_r,
                                      size_word);
              closed    = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              res0      = make_result(KIND_FORMAT, 8'd0, 1'b0, chan_r, rate_r, bits_r,
                                      size_word);
              phase_nxt = PH_DATA;
              if (stg_eof_r) begin
                push1  = 1'b1;
                res1   = make_result(KIND_TRUNC, 8'd0, 1'b1, chan_r, rate_r, bits_r,
                                     size_word);
                closed = 1'b1;
              end
            end
          end else begin
            phase_nxt   = (size_word == 32'd0) ? PH_ID : PH_SKIP;
            is_data_nxt = 1'b1;
          end
        end
      end
      PH_SKIP: begin
        remain_nxt = remain_dec;
        if (remain_dec == 32'd0) begin
          phase_nxt   = PH_ID;
          pos_nxt     = 6'd0;
          is_data_nxt = 1'b1;
        end
      end
      PH_DATA: begin
        remain_nxt = remain_dec;
        push0      = 1'b1;
        if (remain_dec == 32'd0) begin
          res0      = make_result(KIND_PCM, stg_byte_r, 1'b1, chan_r, rate_r, bits_r,
                                  size_r);
          closed    = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          res0 = make_result(KIND_PCM, stg_byte_r, 1'b0, chan_r, rate_r, bits_r, size_r);
          if (stg_eof_r) begin
            push1  = 1'b1;
            res1   = make_result(KIND_TRUNC, 8'd0, 1'b1, chan_r, rate_r, bits_r, size_r);
            closed = 1'b1;
          end
        end
      end
      default: begin
        closed = 1'b1;
      end
    endcase

    if (stg_eof_r) begin
      if (!closed) begin
        if (push0) begin
          push1 = 1'b1;
        end else begin
          push0 = 1'b1;
        end
      end
      phase_nxt   = PH_HEADER;
      pos_nxt     = 6'd0;
      shift_nxt   = 32'd0;
      is_data_nxt = 1'b0;
      remain_nxt  = 32'd0;
      chan_nxt    = 16'd0;
      rate_nxt    = 32'd0;
      bits_nxt    = 8'd0;
      size_nxt    = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r   <= 1'b0;
      phase_r   <= PH_HEADER;
      pos_r     <= 6'd0;
      shift_r   <= 32'd0;
      is_data_r <= 1'b0;
      remain_r  <= 32'd0;
      chan_r    <= 16'd0;
      rate_r    <= 32'd0;
      bits_r    <= 8'd0;
      size_r    <= 32'd0;
    end else begin
      if (in_ready) begin
        stg_v_r <= in_valid;
      end
      if (advance) begin
        phase_r   <= phase_nxt;
        pos_r     <= pos_nxt;
        shift_r   <= shift_nxt;
        is_data_r <= is_data_nxt;
        remain_r  <= remain_nxt;
        chan_r    <= chan_nxt;
        rate_r    <= rate_nxt;
        bits_r    <= bits_nxt;
        size_r    <= size_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_byte_r <= in_file_byte;
      stg_eof_r  <= in_end_of_file;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(advance && push0) + PTR_W'(advance && push1);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      cnt_r    <= cnt_r + CNT_W'(advance && push0) + CNT_W'(advance && push1)
                  - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      if (advance && push0 && (wr_ptr_r == PTR_W'(i))) begin
        fifo_r[i] <= res0;
      end else if (advance && push1 && (wr_ptr1 == PTR_W'(i))) begin
        fifo_r[i] <= res1;
      end
    end
  end

  assign head            = fifo_r[rd_ptr_r];
  assign out_valid       = (cnt_r != '0);
  assign out_kind        = head.kind;
  assign out_channels    = head.channels;
  assign out_sample_rate = head.sample_rate;
  assign out_sample_bits = head.sample_bits;
  assign out_pcm_size    = head.pcm_size;
  assign out_pcm_byte    = head.pcm_byte;
  assign out_last        = head.last;

endmodule
